// ----- rtl/rhgc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the register hazard gap checker: transaction payload structs,
// controller/datapath command and status structs, and fixed field widths.
// Depends on nothing.
package rhgc_pkg;

  // Fixed field widths
  localparam int unsigned BaseW    = 8;
  localparam int unsigned CntW     = 4;
  localparam int unsigned CostW    = 10;
  localparam int unsigned GapReqW  = 10;
  localparam int unsigned IdxW     = 12;
  localparam int unsigned CycW     = 20;
  localparam int unsigned RegNumW  = BaseW + 1;

  localparam logic [CycW-1:0] CycMax = {CycW{1'b1}};

  // Item command codes
  localparam logic CMD_INSTR = 1'b0;
  localparam logic CMD_BLOCK = 1'b1;

  // Source range selector codes
  localparam logic [1:0] RANGE_A    = 2'd0;
  localparam logic [1:0] RANGE_B    = 2'd1;
  localparam logic [1:0] RANGE_C    = 2'd2;
  localparam logic [1:0] RANGE_DONE = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [BaseW-1:0]   dest_base;
    logic [CntW-1:0]    dest_count;
    logic [BaseW-1:0]   src_a_base;
    logic [CntW-1:0]    src_a_count;
    logic [BaseW-1:0]   src_b_base;
    logic [CntW-1:0]    src_b_count;
    logic [BaseW-1:0]   src_c_base;
    logic [CntW-1:0]    src_c_count;
    logic               is_producer;
    logic               is_consumer;
    logic [CostW-1:0]   cycle_cost;
  } in_t;

  typedef struct packed {
    logic               pair_found;
    logic               violation;
    logic [IdxW-1:0]    producer_index;
    logic [IdxW-1:0]    consumer_index;
    logic [CycW-1:0]    gap;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clr_blk;
    logic scan;
    logic wr;
    logic commit;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic wr_done;
    logic out_busy;
  } stat_t;

endpackage

// ----- rtl/rhgc_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rhgc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/rhgc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the hazard gap checker: sequences accept, source scan,
// destination write-back and result hand-off. Depends on rhgc_pkg.
module rhgc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_cmd_i,
  output logic            in_ready_o,
  input  rhgc_pkg::stat_t stat_i,
  output rhgc_pkg::ctrl_t ctrl_o
);
  import rhgc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctrl_o.load = 1'b1;
          if (in_cmd_i == CMD_BLOCK) begin
            ctrl_o.clr_blk = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ctrl_o.wr = 1'b1;
        if (stat_i.wr_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/rhgc_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the hazard gap checker: item register, writer table (valid flops
// plus RAM), newest-producer tracking, running sums and output register.
// Depends on rhgc_pkg and rhgc_ram.
module rhgc_dpath #(
  parameter int unsigned NUM_REGS      = 256,
  parameter int unsigned MAX_RANGE     = 8,
  parameter int unsigned MAX_BLOCK_LEN = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rhgc_pkg::in_t                 in_i,
  input  logic                          cfg_we_i,
  input  logic [rhgc_pkg::GapReqW-1:0]  cfg_wdata_i,
  input  rhgc_pkg::ctrl_t               ctrl_i,
  output rhgc_pkg::stat_t               stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rhgc_pkg::out_t                out_o
);
  import rhgc_pkg::*;

  localparam int unsigned AddrW = $clog2(NUM_REGS);
  localparam int unsigned PosW  = $clog2(MAX_BLOCK_LEN);
  localparam int unsigned RamW  = 1 + PosW + CycW;
  localparam logic [PosW-1:0] PosLast = PosW'(MAX_BLOCK_LEN - 1);

  function automatic logic [CntW-1:0] clamp_cnt(input logic [CntW-1:0] c);
    clamp_cnt = (32'(c) > MAX_RANGE) ? CntW'(MAX_RANGE) : c;
  endfunction

  in_t                  item_q;
  logic [GapReqW-1:0]   req_gap_q;
  logic [1:0]           sel_q;
  logic [CntW-1:0]      elem_q;
  logic [CntW-1:0]      wcnt_q;
  logic                 pend_q;
  logic                 found_q;
  logic [PosW-1:0]      best_pos_q;
  logic [CycW-1:0]      best_cyc_q;
  logic [NUM_REGS-1:0]  wvalid_q;
  logic [CycW-1:0]      run_q;
  logic [PosW-1:0]      pos_q;
  out_t                 out_q;
  logic                 out_valid_q;

  logic [BaseW-1:0]     base_sel;
  logic [CntW-1:0]      cnt_sel;
  logic [CntW-1:0]      n_sel;
  logic [CntW-1:0]      n_dest;
  logic [RegNumW-1:0]   r_scan;
  logic [RegNumW-1:0]   r_wr;
  logic                 scan_in_rng;
  logic                 wr_in_rng;
  logic [AddrW-1:0]     scan_addr;
  logic [AddrW-1:0]     wr_addr;
  logic                 issue;
  logic                 hit;
  logic                 wr_fire;
  logic [RamW-1:0]      rd_data;
  logic                 rd_prod;
  logic [PosW-1:0]      rd_pos;
  logic [CycW-1:0]      rd_cyc;
  logic [CycW:0]        sum_full;
  logic [CycW-1:0]      after;
  logic [CycW-1:0]      gap;
  logic                 newer;

  // Source range select
  always_comb begin
    case (sel_q)
      RANGE_A: begin
        base_sel = item_q.src_a_base;
        cnt_sel  = item_q.src_a_count;
      end
      RANGE_B: begin
        base_sel = item_q.src_b_base;
        cnt_sel  = item_q.src_b_count;
      end
      RANGE_C: begin
        base_sel = item_q.src_c_base;
        cnt_sel  = item_q.src_c_count;
      end
      default: begin
        base_sel = '0;
        cnt_sel  = '0;
      end
    endcase
  end

  assign n_sel       = clamp_cnt(cnt_sel);
  assign n_dest      = clamp_cnt(item_q.dest_count);
  assign r_scan      = RegNumW'(base_sel) + RegNumW'(elem_q);
  assign r_wr        = RegNumW'(item_q.dest_base) + RegNumW'(wcnt_q);
  assign scan_in_rng = 32'(r_scan) < NUM_REGS;
  assign wr_in_rng   = 32'(r_wr) < NUM_REGS;
  assign scan_addr   = AddrW'(r_scan);
  assign wr_addr     = AddrW'(r_wr);
  assign issue       = ctrl_i.scan && (elem_q < n_sel) && scan_in_rng;
  assign hit         = issue && wvalid_q[scan_addr];
  assign wr_fire     = ctrl_i.wr && (wcnt_q < n_dest) && wr_in_rng;

  // Saturating cycle sum after this instruction
  assign sum_full = {1'b0, run_q} + (CycW + 1)'(item_q.cycle_cost);
  assign after    = sum_full[CycW] ? CycMax : sum_full[CycW-1:0];

  // Writer table payload: producer flag, position, cycles after
  rhgc_ram #(
    .Width (RamW),
    .Depth (NUM_REGS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_fire),
    .wr_addr_i (wr_addr),
    .wr_data_i ({item_q.is_producer, pos_q, after}),
    .rd_en_i   (issue),
    .rd_addr_i (scan_addr),
    .rd_data_o (rd_data)
  );

  assign rd_prod = rd_data[RamW-1];
  assign rd_pos  = rd_data[CycW +: PosW];
  assign rd_cyc  = rd_data[CycW-1:0];
  assign newer   = !found_q || (rd_pos > best_pos_q) ||
                   ((rd_pos == best_pos_q) && (rd_cyc > best_cyc_q));

  assign gap = (run_q >= best_cyc_q) ? (run_q - best_cyc_q) : '0;

  // Control state: scan pointers, valid flags, sums, config, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_gap_q   <= '0;
      sel_q       <= RANGE_DONE;
      elem_q      <= '0;
      wcnt_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      wvalid_q    <= '0;
      run_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        req_gap_q <= cfg_wdata_i;
      end

      pend_q <= hit;

      if (ctrl_i.load) begin
        sel_q   <= in_i.is_consumer ? RANGE_A : RANGE_DONE;
        elem_q  <= '0;
        wcnt_q  <= '0;
        found_q <= 1'b0;
      end else if (ctrl_i.scan && (sel_q != RANGE_DONE)) begin
        if ((CntW + 1)'(elem_q) + 1'b1 >= (CntW + 1)'(n_sel)) begin
          sel_q  <= sel_q + 2'd1;
          elem_q <= '0;
        end else begin
          elem_q <= elem_q + 1'b1;
        end
      end

      // Newest producer among the looked-up writers
      if (pend_q && rd_prod && newer) begin
        found_q <= 1'b1;
      end

      if (ctrl_i.wr && (wcnt_q < n_dest)) begin
        wcnt_q <= wcnt_q + 1'b1;
      end

      if (ctrl_i.clr_blk) begin
        wvalid_q <= '0;
        run_q    <= '0;
        pos_q    <= '0;
      end else begin
        if (wr_fire) begin
          wvalid_q[wr_addr] <= 1'b1;
        end
        if (ctrl_i.commit) begin
          run_q <= after;
          if (pos_q != PosLast) begin
            pos_q <= pos_q + 1'b1;
          end
        end
      end

      if (ctrl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q <= in_i;
    end
    if (pend_q && rd_prod && newer) begin
      best_pos_q <= rd_pos;
      best_cyc_q <= rd_cyc;
    end
    if (ctrl_i.commit) begin
      out_q.pair_found     <= found_q;
      out_q.violation      <= found_q && (gap < CycW'(req_gap_q));
      out_q.producer_index <= found_q ? IdxW'(best_pos_q) : '0;
      out_q.consumer_index <= IdxW'(pos_q);
      out_q.gap            <= found_q ? gap : '0;
    end
  end

  assign stat_o.scan_done = (sel_q == RANGE_DONE) && !pend_q;
  assign stat_o.wr_done   = (wcnt_q >= n_dest);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/register_hazard_gap_checker.sv -----
`timescale 1ns / 1ps
// Top level of the register hazard gap checker: controller plus datapath.
// Depends on rhgc_pkg, rhgc_ctrl, rhgc_dpath (and rhgc_ram below it).
//
//   channel  | signals                               | transaction
//   ---------+---------------------------------------+------------------------------
//   in       | in_valid_i / in_ready_o / in_i        | one instruction or block start
//   out      | out_valid_o / out_ready_i / out_o     | one result per instruction
//   cfg      | cfg_we_i / cfg_wdata_i                | required_gap write
//
// One instruction at a time. A consumer scans its three source ranges (each count
// clamped to MAX_RANGE) in the writer table, then writes back its destinations and
// hands off its result; a non-consumer skips the scan; a block start only clears the
// writer valid flags, running sums and position.
// The single read port of the writer table RAM (one source register per cycle) and
// its single write port (one destination per cycle) bound the scan and write-back.
// Reset clears the writer valid flags, running sums and required_gap; no sweep.
// A waiting result stalls only the hand-off: the next transaction is accepted meanwhile.
module register_hazard_gap_checker #(
  parameter int unsigned NUM_REGS      = 256,
  parameter int unsigned MAX_RANGE     = 8,
  parameter int unsigned MAX_BLOCK_LEN = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rhgc_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rhgc_pkg::out_t                out_o,
  input  logic                          cfg_we_i,
  input  logic [rhgc_pkg::GapReqW-1:0]  cfg_wdata_i
);
  import rhgc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rhgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  rhgc_dpath #(
    .NUM_REGS      (NUM_REGS),
    .MAX_RANGE     (MAX_RANGE),
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // A violation needs a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.pair_found || !out_o.violation))
    else $error("violation flagged without a pair");

  // No pair means zeroed producer index and gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.pair_found) |-> ((out_o.producer_index == '0) && (out_o.gap == '0)))
    else $error("unpaired result carries producer data");

  // A block start yields no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_i.cmd == CMD_BLOCK) && !out_valid_o) |=> !out_valid_o)
    else $error("block start produced a result");

  // Nothing is accepted while the controller is busy with the previous instruction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_i.cmd == CMD_INSTR)) |=> !in_ready_o)
    else $error("second transaction accepted mid-instruction");

endmodule
